[rtl/bcps_pkg.sv]
`default_nettype none

package bcps_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_MAX   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_MID   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_LOW   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_DIM   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ADAPTIVE_ON = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_POWER_LO    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_POWER_HI    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_VARIANT     = 3'd7;
  localparam int unsigned CfgDataW = 64;

  // Reset values of the registers
  localparam logic [10:0] RST_LEVEL_MAX = 11'd1441;
  localparam logic [10:0] RST_LEVEL_MID = 11'd784;
  localparam logic [10:0] RST_LEVEL_LOW = 11'd16;
  localparam logic [10:0] RST_LEVEL_DIM = 11'd16;

  // Segment breakpoints and spans
  localparam logic [7:0] BP_UPPER  = 8'd150;
  localparam logic [7:0] BP_MIDDLE = 8'd30;
  localparam logic [7:0] BP_LOWER  = 8'd20;
  localparam logic [7:0] CUTOFF    = 8'd40;
  localparam logic [6:0] SPAN_UPPER  = 7'd105;
  localparam logic [6:0] SPAN_MIDDLE = 7'd120;
  localparam logic [6:0] SPAN_LOWER  = 7'd10;

  // Reciprocals for the segment divide: floor(2^RECIP_SHIFT / span)
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [20:0] RECIP_UPPER  = 21'((64'd1 << RECIP_SHIFT) / 105);
  localparam logic [20:0] RECIP_MIDDLE = 21'((64'd1 << RECIP_SHIFT) / 120);
  localparam logic [20:0] RECIP_LOWER  = 21'((64'd1 << RECIP_SHIFT) / 10);

  // Value clamp and duty reduction
  localparam logic [13:0] VALUE_CLAMP = 14'd1600;
  localparam logic [13:0] VALUE_FLOOR = 14'd16;
  localparam logic [6:0]  DUTY_FULL   = 7'd100;
  localparam logic [6:0]  DUTY_MIN    = 7'd1;

  // Divide by 100 through floor(2^16/100)
  localparam logic [9:0]  RECIP_100 = 10'd655;
  localparam logic [15:0] PCT       = 16'd100;

  // Write words and addresses
  localparam logic [15:0] WORD_FIXED    = 16'hC000;
  localparam logic [15:0] WORD_ADAPTIVE = 16'h5000;
  localparam logic [7:0]  ADDR_BANK     = 8'h00;
  localparam logic [7:0]  ADDR_PWM_NEW  = 8'hB6;
  localparam logic [7:0]  ADDR_PWM_OLD  = 8'hB4;
  localparam logic [7:0]  ADDR_CMT_NEW  = 8'hFF;
  localparam logic [7:0]  ADDR_CMT_OLD  = 8'h28;
  localparam logic [7:0]  ADDR_TBL_NEW  = 8'h79;
  localparam logic [7:0]  ADDR_TBL_OLD  = 8'h76;
  localparam logic [7:0]  TBL_SHORT_MIN = 8'd4;
  localparam logic [2:0]  TBL_LAST_IDX  = 3'd4;

  // Write counts per request, as last step index
  localparam logic [2:0] LAST_STEP_FULL  = 3'd7;
  localparam logic [2:0] LAST_STEP_PLAIN = 3'd2;

  typedef struct packed {
    logic [10:0] level_max;
    logic [10:0] level_mid;
    logic [10:0] level_low;
    logic [10:0] level_dim;
    logic        adaptive_on;
    logic [63:0] power_lo;
    logic [7:0]  power_hi;
    logic        variant;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic        full;   // table writes follow
    logic [6:0]  duty;
    logic [15:0] word;   // PWM word
  } item_t;

  // One register write
  typedef struct packed {
    logic [7:0]  addr;
    logic [15:0] data;
    logic        last;
  } wr_t;

  typedef enum logic [1:0] {
    SEG_UPPER,
    SEG_MIDDLE,
    SEG_LOWER,
    SEG_FLAT
  } seg_e;

  typedef enum logic [1:0] {
    WK_BANK,
    WK_TABLE,
    WK_PWM,
    WK_COMMIT
  } wkind_e;

  // Power table entry k (0..8)
  function automatic logic [7:0] power_entry(cfg_t c, logic [3:0] k);
    logic [7:0] e;
    if (k[3]) begin
      e = c.power_hi;
    end else begin
      e = c.power_lo[{k[2:0], 3'b000} +: 8];
    end
    return e;
  endfunction

  // x / 100 for x up to 25500: reciprocal estimate and one correction
  function automatic logic [7:0] div100(logic [14:0] x);
    logic [24:0] p;
    logic [7:0]  q0;
    logic [15:0] qs;
    logic [14:0] r;
    p  = 25'(x) * 25'(RECIP_100);
    q0 = p[23:16];
    qs = 16'(q0) * PCT;
    r  = x - qs[14:0];
    return (r >= PCT[14:0]) ? q0 + 8'd1 : q0;
  endfunction

endpackage

`default_nettype wire

[rtl/bcps_fifo.sv]
`default_nettype none

module bcps_fifo #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth     = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [DataWidth-1:0]         wdata_i,
  input  wire logic                         pop_i,
  output logic      [DataWidth-1:0]         rdata_o,
  output logic                              full_o,
  output logic                              empty_o,
  output logic      [$clog2(Depth+1)-1:0]   count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[rtl/bcps_front.sv]
`default_nettype none

module bcps_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bcps_pkg::cfg_t cfg_i,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire logic [7:0]     brightness_i,
  output bcps_pkg::item_t     item_o,
  output logic                item_push_o,
  input  wire logic           item_full_i
);

  import bcps_pkg::*;

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] vld_q, vld_d;
  logic              adv, accept;

  // stage 1: segment select
  seg_e        s1_seg_d, s1_seg_q;
  logic [6:0]  s1_pos_d, s1_pos_q;
  logic [10:0] s1_absd_d, s1_absd_q;
  logic        s1_neg_d, s1_neg_q;
  logic [10:0] s1_lo_d, s1_lo_q;
  logic        s1_zero_q, s1_gt40_q;
  logic [10:0] hi, lo;
  logic [11:0] diff;
  // stage 2: magnitude of the product
  logic [17:0] s2_mag_q;
  seg_e        s2_seg_q;
  logic        s2_neg_q, s2_zero_q, s2_gt40_q;
  logic [10:0] s2_lo_q;
  // stage 3: reciprocal product
  logic [38:0] s3_prod_q;
  logic [20:0] recip;
  logic [17:0] s3_mag_q;
  seg_e        s3_seg_q;
  logic        s3_neg_q, s3_zero_q, s3_gt40_q;
  logic [10:0] s3_lo_q;
  // stage 4: corrected quotient
  logic [6:0]  span;
  logic [14:0] q0;
  logic [21:0] qs;
  logic [17:0] rem;
  logic [11:0] q_d, s4_q_q;
  logic        s4_neg_q, s4_zero_q, s4_gt40_q;
  logic [10:0] s4_lo_q;
  // stage 5: value, clamp, duty
  logic [13:0] val;
  logic [6:0]  duty_d, s5_duty_q;
  logic        s5_gt40_q;
  // stage 6: products for the table check
  logic [14:0] s6_p3_q, s6_p7_q;
  logic [6:0]  s6_duty_q;
  logic        s6_gt40_q;
  // stage 7: classification
  logic [7:0]  s3v, s7v;
  item_t       s7_item_q, item_d;

  // whole pipeline moves unless the last word cannot leave
  assign adv    = !vld_q[Stages-1] || !item_full_i;
  assign full_o = !adv;
  assign accept = push_i && adv;

  always_comb begin
    vld_d = vld_q;
    if (adv) begin
      vld_d = {vld_q[Stages-2:0], accept};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // segment and anchors for the incoming level
  always_comb begin
    if (brightness_i >= BP_UPPER) begin
      s1_seg_d = SEG_UPPER;
      s1_pos_d = 7'(brightness_i - BP_UPPER);
      hi       = cfg_i.level_max;
      lo       = cfg_i.level_mid;
    end else if (brightness_i >= BP_MIDDLE) begin
      s1_seg_d = SEG_MIDDLE;
      s1_pos_d = 7'(brightness_i - BP_MIDDLE);
      hi       = cfg_i.level_mid;
      lo       = cfg_i.level_low;
    end else if (brightness_i >= BP_LOWER) begin
      s1_seg_d = SEG_LOWER;
      s1_pos_d = 7'(brightness_i - BP_LOWER);
      hi       = cfg_i.level_low;
      lo       = cfg_i.level_dim;
    end else begin
      s1_seg_d = SEG_FLAT;
      s1_pos_d = '0;
      hi       = cfg_i.level_dim;
      lo       = cfg_i.level_dim;
    end
    diff      = {1'b0, hi} - {1'b0, lo};
    s1_neg_d  = diff[11];
    s1_absd_d = diff[11] ? 11'(-diff) : diff[10:0];
    s1_lo_d   = lo;
  end

  // reciprocal and span per segment
  always_comb begin
    case (s3_seg_q)
      SEG_UPPER:  span = SPAN_UPPER;
      SEG_MIDDLE: span = SPAN_MIDDLE;
      default:    span = SPAN_LOWER;
    endcase
    case (s2_seg_q)
      SEG_UPPER:  recip = RECIP_UPPER;
      SEG_MIDDLE: recip = RECIP_MIDDLE;
      default:    recip = RECIP_LOWER;
    endcase
  end

  // quotient estimate is low by at most one
  always_comb begin
    q0  = s3_prod_q[38:RECIP_SHIFT];
    qs  = 22'(q0) * 22'(span);
    rem = s3_mag_q - qs[17:0];
    q_d = (rem >= 18'(span)) ? 12'(q0 + 15'd1) : q0[11:0];
  end

  // value, clamp and duty
  always_comb begin
    val = s4_neg_q ? ({3'b000, s4_lo_q} - {2'b00, s4_q_q})
                   : ({3'b000, s4_lo_q} + {2'b00, s4_q_q});
    if (s4_zero_q) begin
      duty_d = '0;
    end else if (val[13]) begin
      duty_d = DUTY_MIN;
    end else if (val > VALUE_CLAMP) begin
      duty_d = DUTY_FULL;
    end else if (val < VALUE_FLOOR) begin
      duty_d = DUTY_MIN;
    end else begin
      duty_d = val[10:4];
    end
  end

  // path choice
  always_comb begin
    s3v = div100(s6_p3_q);
    s7v = div100(s6_p7_q);
    item_d.duty = s6_duty_q;
    if (!s6_gt40_q || !cfg_i.adaptive_on) begin
      item_d.full = 1'b0;
      item_d.word = WORD_FIXED | 16'(s6_duty_q);
    end else if (s7v < TBL_SHORT_MIN) begin
      item_d.full = 1'b0;
      item_d.word = WORD_FIXED | 16'((s3v == '0) ? 8'd1 : s3v);
    end else begin
      item_d.full = 1'b1;
      item_d.word = WORD_ADAPTIVE | {5'b00000, s6_duty_q, 4'b0000};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_seg_q  <= s1_seg_d;
      s1_pos_q  <= s1_pos_d;
      s1_absd_q <= s1_absd_d;
      s1_neg_q  <= s1_neg_d;
      s1_lo_q   <= s1_lo_d;
      s1_zero_q <= (brightness_i == '0);
      s1_gt40_q <= (brightness_i > CUTOFF);

      s2_mag_q  <= 18'(s1_pos_q) * 18'(s1_absd_q);
      s2_seg_q  <= s1_seg_q;
      s2_neg_q  <= s1_neg_q;
      s2_zero_q <= s1_zero_q;
      s2_gt40_q <= s1_gt40_q;
      s2_lo_q   <= s1_lo_q;

      s3_prod_q <= 39'(s2_mag_q) * 39'(recip);
      s3_mag_q  <= s2_mag_q;
      s3_seg_q  <= s2_seg_q;
      s3_neg_q  <= s2_neg_q;
      s3_zero_q <= s2_zero_q;
      s3_gt40_q <= s2_gt40_q;
      s3_lo_q   <= s2_lo_q;

      s4_q_q    <= q_d;
      s4_neg_q  <= s3_neg_q;
      s4_zero_q <= s3_zero_q;
      s4_gt40_q <= s3_gt40_q;
      s4_lo_q   <= s3_lo_q;

      s5_duty_q <= duty_d;
      s5_gt40_q <= s4_gt40_q;

      s6_p3_q   <= 15'(power_entry(cfg_i, 4'd3)) * 15'(s5_duty_q);
      s6_p7_q   <= 15'(power_entry(cfg_i, 4'd7)) * 15'(s5_duty_q);
      s6_duty_q <= s5_duty_q;
      s6_gt40_q <= s5_gt40_q;

      s7_item_q <= item_d;
    end
  end

  assign item_o      = s7_item_q;
  assign item_push_o = vld_q[Stages-1] && adv;

endmodule

`default_nettype wire

[rtl/bcps_back.sv]
`default_nettype none

module bcps_back #(
  parameter int unsigned OutDepth = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bcps_pkg::cfg_t                  cfg_i,
  input  wire bcps_pkg::item_t                 item_i,
  input  wire logic                            item_empty_i,
  output logic                                 item_pop_o,
  input  wire logic [$clog2(OutDepth+1)-1:0]   out_count_i,
  output bcps_pkg::wr_t                        wr_o,
  output logic                                 wr_push_o
);

  import bcps_pkg::*;

  localparam int unsigned CntW  = $clog2(OutDepth + 1);
  localparam int unsigned UsedW = CntW + 1;

  // sequencer
  logic        busy_q, busy_d;
  logic [2:0]  step_q, step_d;
  item_t       cur_q, cur_d;
  logic        issue, last_step, load;
  logic [UsedW-1:0] used;

  // issue stage
  wkind_e      kind;
  logic [2:0]  tidx;
  // stage 1
  logic        v1_q;
  wkind_e      k1_q;
  logic [2:0]  t1_q;
  logic        l1_q;
  logic [6:0]  duty1_q;
  logic [15:0] word1_q;
  logic [3:0]  ea, eb;
  // stage 2
  logic        v2_q;
  wkind_e      k2_q;
  logic [2:0]  t2_q;
  logic        l2_q;
  logic [15:0] word2_q;
  logic [14:0] pa_q, pb_q;
  logic [7:0]  sa, sb;
  wr_t         wr_d;

  // output space for everything in flight plus this write
  assign used  = UsedW'(out_count_i) + UsedW'(v1_q) + UsedW'(v2_q);
  assign issue = busy_q && (used < UsedW'(OutDepth));
  assign last_step = cur_q.full ? (step_q == LAST_STEP_FULL) : (step_q == LAST_STEP_PLAIN);
  assign load  = (!busy_q || (issue && last_step)) && !item_empty_i;
  assign item_pop_o = load;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    cur_d  = cur_q;
    if (load) begin
      busy_d = 1'b1;
      step_d = '0;
      cur_d  = item_i;
    end else if (issue) begin
      busy_d = !last_step;
      step_d = step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      v1_q   <= issue;
      v2_q   <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // step to write kind
  always_comb begin
    tidx = 3'(step_q - 3'd1);
    if (cur_q.full) begin
      case (step_q)
        3'd0:                                kind = WK_BANK;
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5:         kind = WK_TABLE;
        3'd6:                                kind = WK_PWM;
        default:                             kind = WK_COMMIT;
      endcase
    end else begin
      case (step_q)
        3'd0:    kind = WK_BANK;
        3'd1:    kind = WK_PWM;
        default: kind = WK_COMMIT;
      endcase
    end
  end

  // stage 1: entry pair times duty
  assign ea = {t1_q, 1'b0};
  assign eb = {t1_q, 1'b1};

  always_ff @(posedge clk_i) begin
    k1_q    <= kind;
    t1_q    <= tidx;
    l1_q    <= last_step;
    duty1_q <= cur_q.duty;
    word1_q <= cur_q.word;

    k2_q    <= k1_q;
    t2_q    <= t1_q;
    l2_q    <= l1_q;
    word2_q <= word1_q;
    pa_q    <= 15'(power_entry(cfg_i, ea)) * 15'(duty1_q);
    pb_q    <= (t1_q == TBL_LAST_IDX) ? '0 : 15'(power_entry(cfg_i, eb)) * 15'(duty1_q);
  end

  // stage 2: scale and form the write
  always_comb begin
    sa = div100(pa_q);
    sb = div100(pb_q);
    wr_d.last = l2_q;
    unique case (k2_q)
      WK_BANK: begin
        wr_d.addr = ADDR_BANK;
        wr_d.data = {15'd0, cfg_i.variant};
      end
      WK_TABLE: begin
        wr_d.addr = (cfg_i.variant ? ADDR_TBL_NEW : ADDR_TBL_OLD) + 8'(t2_q);
        wr_d.data = {sa, sb};
      end
      WK_PWM: begin
        wr_d.addr = cfg_i.variant ? ADDR_PWM_NEW : ADDR_PWM_OLD;
        wr_d.data = word2_q;
      end
      default: begin
        wr_d.addr = cfg_i.variant ? ADDR_CMT_NEW : ADDR_CMT_OLD;
        wr_d.data = '0;
      end
    endcase
  end

  assign wr_o      = wr_d;
  assign wr_push_o = v2_q;

endmodule

`default_nettype wire

[rtl/backlight_cabc_pwm_sequencer.sv]
`default_nettype none

// Brightness to PWM register-write sequencer. Each brightness word pushed in
// becomes a run of register writes (address, data, last flag) popped from
// the result side: three writes on the plain path or when the scaled power
// table is too small, eight when the power table is written. The back end
// issues one write per cycle while the result queue has room, and a waiting
// request follows the previous one with no gap. The front end maps a
// brightness to a duty in a seven-stage pipeline (segment select, multiply,
// reciprocal divide, clamp, table check) and accepts one word per cycle
// while its hand-off queue has room; a request's writes then pass the
// hand-off queue and the back end before they reach the result ports.
// Configuration writes take effect at once and belong to idle periods only.
module backlight_cabc_pwm_sequencer #(
  parameter int unsigned ItemDepth = 2,
  parameter int unsigned OutDepth  = 4
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire logic [bcps_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  wire logic [bcps_pkg::CfgDataW-1:0]         cfg_data_i,
  // requests
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic [7:0]                            brightness_i,
  // writes
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic [7:0]                                 reg_addr_o,
  output logic [15:0]                                reg_data_o,
  output logic                                       last_write_o
);

  import bcps_pkg::*;

  cfg_t  cfg_q;
  item_t item_w, item_rd;
  logic  item_push, item_full, item_empty, item_pop;
  wr_t   wr_w, wr_rd;
  logic  wr_push;
  logic [$clog2(OutDepth+1)-1:0] out_count;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_max   <= RST_LEVEL_MAX;
      cfg_q.level_mid   <= RST_LEVEL_MID;
      cfg_q.level_low   <= RST_LEVEL_LOW;
      cfg_q.level_dim   <= RST_LEVEL_DIM;
      cfg_q.adaptive_on <= 1'b1;
      cfg_q.power_lo    <= '0;
      cfg_q.power_hi    <= '0;
      cfg_q.variant     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEVEL_MAX:   cfg_q.level_max   <= cfg_data_i[10:0];
        CFG_LEVEL_MID:   cfg_q.level_mid   <= cfg_data_i[10:0];
        CFG_LEVEL_LOW:   cfg_q.level_low   <= cfg_data_i[10:0];
        CFG_LEVEL_DIM:   cfg_q.level_dim   <= cfg_data_i[10:0];
        CFG_ADAPTIVE_ON: cfg_q.adaptive_on <= cfg_data_i[0];
        CFG_POWER_LO:    cfg_q.power_lo    <= cfg_data_i;
        CFG_POWER_HI:    cfg_q.power_hi    <= cfg_data_i[7:0];
        CFG_VARIANT:     cfg_q.variant     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // duty pipeline and path choice
  bcps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_o       (full),
    .brightness_i (brightness_i),
    .item_o       (item_w),
    .item_push_o  (item_push),
    .item_full_i  (item_full)
  );

  // hand-off between front and back
  bcps_fifo #(
    .DataWidth ($bits(item_t)),
    .Depth     (ItemDepth)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_push),
    .wdata_i (item_w),
    .pop_i   (item_pop),
    .rdata_o (item_rd),
    .full_o  (item_full),
    .empty_o (item_empty),
    .count_o ()
  );

  // write sequencer
  bcps_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item_rd),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .out_count_i  (out_count),
    .wr_o         (wr_w),
    .wr_push_o    (wr_push)
  );

  // result queue
  bcps_fifo #(
    .DataWidth ($bits(wr_t)),
    .Depth     (OutDepth)
  ) u_wr_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wr_push),
    .wdata_i (wr_w),
    .pop_i   (pop),
    .rdata_o (wr_rd),
    .full_o  (),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign reg_addr_o   = wr_rd.addr;
  assign reg_data_o   = wr_rd.data;
  assign last_write_o = wr_rd.last;

endmodule

`default_nettype wire

[dv/bcps_write_monitor.sv]
`timescale 1ns / 100ps

// Watches the request and write channels of the sequencer, keeps a shadow of
// its registers, predicts the register writes of every accepted brightness
// word and compares each popped write with the oldest one predicted.
module bcps_write_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bcps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push_i,
  input  logic                          full_i,
  input  logic [7:0]                    brightness_i,
  input  logic                          empty_i,
  input  logic                          pop_i,
  input  logic [7:0]                    reg_addr_i,
  input  logic [15:0]                   reg_data_i,
  input  logic                          last_write_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   writes_pending_o,
  output int unsigned                   writes_checked_o
);

  import bcps_pkg::*;

  cfg_t        shadow;
  wr_t         write_q[$];
  int unsigned mismatch_cnt  = 0;
  int unsigned checked_cnt   = 0;
  int unsigned pending_cnt   = 0;

  assign mismatches_o     = mismatch_cnt;
  assign writes_pending_o = pending_cnt;
  assign writes_checked_o = checked_cnt;

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: write %0d: %s is 0x%0h, want 0x%0h", $time, checked_cnt, field,
             got, want);
    mismatch_cnt++;
  endtask

  // One segment of the level curve; int division truncates toward zero
  function automatic int seg_value(int pos, int span, int hi, int lo);
    return pos * (hi - lo) / span + lo;
  endfunction

  function automatic logic [6:0] duty_for(logic [7:0] lvl, cfg_t c);
    int v;
    if (lvl == 8'd0) return 7'd0;
    if (lvl >= 8'd150)
      v = seg_value(int'(lvl) - 150, 105, int'(c.level_max), int'(c.level_mid));
    else if (lvl >= 8'd30)
      v = seg_value(int'(lvl) - 30, 120, int'(c.level_mid), int'(c.level_low));
    else if (lvl >= 8'd20)
      v = seg_value(int'(lvl) - 20, 10, int'(c.level_low), int'(c.level_dim));
    else
      v = int'(c.level_dim);
    if (v < 0) v = 0;
    if (v > 1600) v = 1600;
    if (v < 16) return 7'd1;
    return 7'(v >> 4);
  endfunction

  // Power entry k scaled by duty/100
  function automatic logic [7:0] scaled_power(cfg_t c, int k, logic [6:0] duty);
    int e;
    e = (k == 8) ? int'(c.power_hi) : int'(c.power_lo[8*k +: 8]);
    return 8'(e * int'(duty) / 100);
  endfunction

  // Work out the whole write run of one request and queue it
  function automatic void queue_writes(logic [7:0] lvl, cfg_t c);
    wr_t         seq[8];
    logic [7:0]  s[9];
    logic [6:0]  duty;
    logic [7:0]  base;
    logic [15:0] word;
    int          n;
    duty = duty_for(lvl, c);
    for (int k = 0; k < 9; k++) s[k] = scaled_power(c, k, duty);
    seq[0] = '{ADDR_BANK, {15'd0, c.variant}, 1'b0};
    n = 1;
    if (lvl <= CUTOFF || !c.adaptive_on) begin
      word = WORD_FIXED | 16'(duty);
    end else if (s[7] < TBL_SHORT_MIN) begin
      word = WORD_FIXED | 16'((s[3] < 8'd1) ? 8'd1 : s[3]);
    end else begin
      base = c.variant ? ADDR_TBL_NEW : ADDR_TBL_OLD;
      for (int k = 0; k < 4; k++) begin
        seq[n] = '{base + 8'(k), {s[2*k], s[2*k+1]}, 1'b0};
        n++;
      end
      seq[n] = '{base + 8'd4, {s[8], 8'h00}, 1'b0};
      n++;
      word = WORD_ADAPTIVE | (16'(duty) << 4);
    end
    seq[n] = '{c.variant ? ADDR_PWM_NEW : ADDR_PWM_OLD, word, 1'b0};
    n++;
    seq[n] = '{c.variant ? ADDR_CMT_NEW : ADDR_CMT_OLD, 16'h0000, 1'b1};
    n++;
    for (int i = 0; i < n; i++) write_q.push_back(seq[i]);
  endfunction

  // Shadow registers, prediction and comparison on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    wr_t want;
    if (!rst_ni) begin
      shadow <= '{level_max: RST_LEVEL_MAX, level_mid: RST_LEVEL_MID,
                  level_low: RST_LEVEL_LOW, level_dim: RST_LEVEL_DIM,
                  adaptive_on: 1'b1, power_lo: 64'd0, power_hi: 8'd0,
                  variant: 1'b1};
      write_q.delete();
      pending_cnt <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LEVEL_MAX:   shadow.level_max   <= cfg_data_i[10:0];
          CFG_LEVEL_MID:   shadow.level_mid   <= cfg_data_i[10:0];
          CFG_LEVEL_LOW:   shadow.level_low   <= cfg_data_i[10:0];
          CFG_LEVEL_DIM:   shadow.level_dim   <= cfg_data_i[10:0];
          CFG_ADAPTIVE_ON: shadow.adaptive_on <= cfg_data_i[0];
          CFG_POWER_LO:    shadow.power_lo    <= cfg_data_i;
          CFG_POWER_HI:    shadow.power_hi    <= cfg_data_i[7:0];
          CFG_VARIANT:     shadow.variant     <= cfg_data_i[0];
          default: ;
        endcase
      end
      // popped word against the oldest prediction
      if (pop_i && !empty_i) begin
        if (write_q.size() == 0) begin
          report_mismatch("write with none outstanding, addr", reg_addr_i, 0);
        end else begin
          want = write_q.pop_front();
          if (reg_addr_i != want.addr) report_mismatch("addr", reg_addr_i, want.addr);
          if (reg_data_i != want.data) report_mismatch("data", reg_data_i, want.data);
          if (last_write_i != want.last)
            report_mismatch("last", last_write_i, want.last);
        end
        checked_cnt++;
      end
      if (push_i && !full_i) queue_writes(brightness_i, shadow);
      pending_cnt <= write_q.size();
    end
  end

endmodule

[dv/backlight_cabc_pwm_sequencer_tb.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the sequencer; checking lives in the monitor.
module backlight_cabc_pwm_sequencer_tb;
  import bcps_pkg::*;

  localparam logic [7:0] BREAK_LEVELS [16] = '{8'd0, 8'd1, 8'd19, 8'd20, 8'd21, 8'd29,
                                               8'd30, 8'd31, 8'd39, 8'd40, 8'd41,
                                               8'd149, 8'd150, 8'd151, 8'd254, 8'd255};
  localparam int IDLE_MODES [4]  = '{0, 45, 0, 36};
  localparam int STALL_MODES [4] = '{0, 0, 45, 36};

  logic                clk          = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx      = '0;
  logic [CfgDataW-1:0] cfg_data     = '0;
  logic                push         = 1'b0;
  logic                full;
  logic [7:0]          brightness   = 8'd0;
  logic                empty;
  logic                pop          = 1'b0;
  logic [7:0]          reg_addr;
  logic [15:0]         reg_data;
  logic                last_write;
  logic                hold_off     = 1'b0;

  int unsigned mismatches;
  int unsigned writes_pending;
  int unsigned writes_checked;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int unsigned levels_sent  = 0;
  int unsigned settings_cnt = 0;

  backlight_cabc_pwm_sequencer dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .brightness_i (brightness),
    .empty        (empty),
    .pop          (pop),
    .reg_addr_o   (reg_addr),
    .reg_data_o   (reg_data),
    .last_write_o (last_write)
  );

  bcps_write_monitor u_monitor (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .push_i           (push),
    .full_i           (full),
    .brightness_i     (brightness),
    .empty_i          (empty),
    .pop_i            (pop),
    .reg_addr_i       (reg_addr),
    .reg_data_i       (reg_data),
    .last_write_i     (last_write),
    .mismatches_o     (mismatches),
    .writes_pending_o (writes_pending),
    .writes_checked_o (writes_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Write side: random stalls, or a long hold-off
  always @(posedge clk) begin
    pop <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Offer one brightness word, with random idle cycles first
  task automatic push_level(input logic [7:0] lvl);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    brightness <= lvl;
    @(posedge clk);
    while (full) @(posedge clk);
    levels_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
  endtask

  // Write all registers; upper data bits of narrow registers carry junk
  task automatic apply_cfg(input cfg_t c);
    logic [63:0]        junk;
    logic [CfgIdxW-1:0] idx;
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      junk   = {$urandom, $urandom};
      idx    = CfgIdxW'(i);
      cfg_we  <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        CFG_LEVEL_MAX:   cfg_data <= {junk[63:11], c.level_max};
        CFG_LEVEL_MID:   cfg_data <= {junk[63:11], c.level_mid};
        CFG_LEVEL_LOW:   cfg_data <= {junk[63:11], c.level_low};
        CFG_LEVEL_DIM:   cfg_data <= {junk[63:11], c.level_dim};
        CFG_ADAPTIVE_ON: cfg_data <= {junk[63:1], c.adaptive_on};
        CFG_POWER_LO:    cfg_data <= c.power_lo;
        CFG_POWER_HI:    cfg_data <= {junk[63:8], c.power_hi};
        default:         cfg_data <= {junk[63:1], c.variant};
      endcase
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  function automatic logic [10:0] pick_anchor();
    case ($urandom_range(7))
      0:       return 11'd0;
      1:       return 11'd1600;
      2:       return 11'd2047;
      default: return 11'($urandom_range(2047));
    endcase
  endfunction

  // Mix of table shapes: wide, saturated, tiny (entries up to 7) and empty
  function automatic logic [63:0] pick_power();
    logic [63:0] p;
    case ($urandom_range(3))
      0: p = {$urandom, $urandom};
      1: p = '1;
      2: for (int k = 0; k < 8; k++) p[8*k +: 8] = 8'($urandom_range(7));
      default: p = '0;
    endcase
    return p;
  endfunction

  // Flavour 0 and 1 are the all-low and all-high extremes
  function automatic cfg_t random_settings(int flavour);
    cfg_t c;
    if (flavour == 0) begin
      c = '{11'd0, 11'd0, 11'd0, 11'd0, 1'b1, 64'd0, 8'd0, 1'b0};
    end else if (flavour == 1) begin
      c = '{11'd2047, 11'd2047, 11'd2047, 11'd2047, 1'b1, '1, 8'hFF, 1'b1};
    end else begin
      c.level_max   = pick_anchor();
      c.level_mid   = pick_anchor();
      c.level_low   = pick_anchor();
      c.level_dim   = pick_anchor();
      c.adaptive_on = ($urandom_range(3) != 0);
      c.power_lo    = pick_power();
      c.power_hi    = 8'($urandom);
      c.variant     = 1'($urandom);
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_level();
    if ($urandom_range(3) == 0) return BREAK_LEVELS[$urandom_range(15)];
    return 8'($urandom_range(255));
  endfunction

  task automatic run_phase(input int n_items, input int mode, input bit mid_pause);
    idle_pct  = IDLE_MODES[mode];
    stall_pct = STALL_MODES[mode];
    for (int i = 0; i < n_items; i++) begin
      if (mid_pause && i == n_items / 2) begin
        push <= 1'b0;
        wait_drained();
      end
      push_level(pick_level());
    end
    push <= 1'b0;
    wait_drained();
  endtask

  initial begin
    logic [7:0] dir_reset [8];
    logic [7:0] dir_down [8];
    logic [7:0] dir_clamp [8];
    cfg_t       c;
    dir_reset = '{8'd0, 8'd19, 8'd20, 8'd30, 8'd40, 8'd41, 8'd150, 8'd255};
    dir_down  = '{8'd255, 8'd200, 8'd150, 8'd100, 8'd41, 8'd40, 8'd25, 8'd10};
    dir_clamp = '{8'd0, 8'd1, 8'd20, 8'd31, 8'd149, 8'd151, 8'd254, 8'd255};

    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed: registers at reset, short adaptive path
    foreach (dir_reset[i]) push_level(dir_reset[i]);
    push <= 1'b0;
    wait_drained();

    // directed: alternating anchors, falling levels, saturated table, older address map
    c = '{11'd0, 11'd2047, 11'd5, 11'd2047, 1'b1, '1, 8'hFF, 1'b0};
    apply_cfg(c);
    foreach (dir_down[i]) push_level(dir_down[i]);
    push <= 1'b0;
    wait_drained();

    // directed: anchors at and past the clamp, plain path only
    c = '{11'd2047, 11'd1600, 11'd0, 11'd0, 1'b0, 64'h0102_0304_0506_0708, 8'h09, 1'b1};
    apply_cfg(c);
    foreach (dir_clamp[i]) push_level(dir_clamp[i]);
    push <= 1'b0;
    wait_drained();

    // random phases across settings and idling modes
    for (int p = 0; p < 8; p++) begin
      apply_cfg(random_settings(p));
      run_phase(46, p % 4, p == 5);
    end

    // back-pressure: writes held off while requests keep coming
    apply_cfg(random_settings(1));
    idle_pct  = 0;
    stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        for (int i = 0; i < 40; i++) push_level(pick_level());
        push <= 1'b0;
      end
    join
    wait_drained();
    repeat (24) @(posedge clk);

    $display("Covered %0d brightness words under %0d register settings,", levels_sent,
             settings_cnt);
    $display("with %0d register writes compared and %0d mismatches.", writes_checked,
             mismatches);
    if (mismatches == 0 && writes_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bcps_pkg.sv
rtl/bcps_fifo.sv
rtl/bcps_front.sv
rtl/bcps_back.sv
rtl/backlight_cabc_pwm_sequencer.sv
dv/bcps_write_monitor.sv
dv/backlight_cabc_pwm_sequencer_tb.sv
